// ----- hw/rtl/db7_pkg.sv -----
`default_nettype none
package db7_pkg;

	localparam int TAPS        = 14;
	localparam int SAMPLE_BITS = 16;
	localparam int IN_W        = 16;
	localparam int COEF_W      = 16;
	localparam int OUT_W       = 18;
	localparam int FRAC_BITS   = 15;
	localparam int FILL_W      = $clog2(TAPS + 1);
	localparam int HALF_TAPS   = TAPS / 2;
	localparam int PROD_W      = SAMPLE_BITS + COEF_W;
	localparam int ACC_W       = PROD_W + $clog2(TAPS) + 1;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]      coef_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef logic signed [OUT_W-1:0]       out_t;

	// db7 low-pass analysis taps, round(c * 2^15)
	localparam coef_t LO_Q15 [TAPS] = '{
		16'sd2551, 16'sd12994, 16'sd23892, 16'sd15394, -16'sd4716, -16'sd7341, 16'sd2337,
		16'sd2642, -16'sd1246, -16'sd543, 16'sd411, 16'sd14, -16'sd59, 16'sd12
	};

	// High-pass tap j: quadrature mirror of the low-pass set
	function automatic coef_t hi_coef(input int j);
		coef_t c;
		c = LO_Q15[TAPS - 1 - j];
		if ((j % 2) == 1) begin
			c = -c;
		end
		return c;
	endfunction

	// Round half up to sample units, then clamp to the output range
	function automatic out_t round_sat(input acc_t acc);
		acc_t r;
		r = (acc + ACC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > ACC_W'(OUT_MAX)) begin
			return OUT_MAX;
		end else if (r < ACC_W'(OUT_MIN)) begin
			return OUT_MIN;
		end
		return OUT_W'(r);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/db7_dwt_analysis_filter_bank.sv -----
`default_nettype none
// One level of a db7 wavelet analysis filter bank.
// Input channel (sample_valid / sample_ready): one signed sample per transfer,
// already boundary-extended by the source. frame_start set on a transfer
// restarts the window fill count and the decimation phase before that sample
// enters; older window contents stay but yield nothing until 14 new samples
// of the frame have arrived.
// Output channel (result_valid / result_ready): one approx/detail pair per
// transfer, emitted on the sample that fills the 14-tap window and then on
// every second sample after it. Samples that emit nothing leave no trace on
// the output.
// The result of a sample passes through the window snapshot, tap products,
// half sums, and round and clamp into the output register. Throughput: one
// sample per cycle while sample_ready is high, set by the four-stage
// pipeline, which stalls when result_ready holds back a pending result.
// Stalls: each stage holds its contents while the stage after it is full
// and not advancing, so empty stages keep filling while result_ready is low.
// sample_ready drops only when every stage holds a pending result.
// Reset: arst_n clears the window to zero, the fill count, the phase and all
// pipeline valid flags; no result is pending afterwards.
module db7_dwt_analysis_filter_bank import db7_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    sample_valid,
	output logic                         sample_ready,
	input  wire logic signed [IN_W-1:0]  sample,
	input  wire logic                    frame_start,
	output logic                         result_valid,
	input  wire logic                    result_ready,
	output logic signed [OUT_W-1:0]      approx,
	output logic signed [OUT_W-1:0]      detail
);

	// Window: entry 0 is the oldest sample
	sample_t           window_q [TAPS];
	logic [FILL_W-1:0] fill_q;
	logic              phase_q;

	logic [IN_W+SAMPLE_BITS-1:0] sample_ext;
	sample_t                     sample_in;
	logic [FILL_W-1:0]           fill_base;
	logic [FILL_W-1:0]           fill_next;
	logic                        phase_base;
	logic                        full;
	logic                        emit;
	logic                        in_xfer;

	// Pipeline stage registers
	logic    v_s1, v_s2, v_s3;
	sample_t win_s1 [TAPS];
	prod_t   plo_s2 [TAPS];
	prod_t   phi_s2 [TAPS];
	acc_t    slo_s3 [2];
	acc_t    shi_s3 [2];

	logic adv_s1, adv_s2, adv_s3, adv_out;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	// Keep the low SAMPLE_BITS bits of the port, zero above the port width
	assign sample_ext = {{SAMPLE_BITS{1'b0}}, sample};
	assign sample_in  = sample_t'(sample_ext[SAMPLE_BITS-1:0]);

	// Fill and decimation bookkeeping for the sample being transferred
	always_comb begin
		fill_base  = frame_start ? '0 : fill_q;
		phase_base = frame_start ? 1'b0 : phase_q;
		fill_next  = (fill_base < FILL_W'(TAPS)) ? fill_base + 1'b1 : fill_base;
		full       = (fill_next == FILL_W'(TAPS));
		emit       = full && !phase_base;
	end

	// A stage may load when it is empty or its contents move on this cycle
	assign rdy_out = !result_valid || result_ready;
	assign rdy_s3  = !v_s3 || rdy_out;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign sample_ready = rdy_s1;
	assign in_xfer      = sample_valid && sample_ready;

	assign adv_s1  = in_xfer && emit;
	assign adv_s2  = v_s1 && rdy_s2;
	assign adv_s3  = v_s2 && rdy_s3;
	assign adv_out = v_s3 && rdy_out;

	// Window, fill count and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				window_q[i] <= '0;
			end
			fill_q  <= '0;
			phase_q <= 1'b0;
		end else if (in_xfer) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				window_q[i] <= window_q[i + 1];
			end
			window_q[TAPS - 1] <= sample_in;
			fill_q             <= fill_next;
			phase_q            <= full ? !phase_base : phase_base;
		end
	end

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= adv_s1;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				result_valid <= v_s3;
			end
		end
	end

	// Stage 1: snapshot of the shifted window including the new sample
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				win_s1[i] <= window_q[i + 1];
			end
			win_s1[TAPS - 1] <= sample_in;
		end
	end

	// Stage 2: constant-coefficient products for both filters
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int j = 0; j < TAPS; j++) begin
				plo_s2[j] <= PROD_W'(win_s1[j]) * PROD_W'(LO_Q15[j]);
				phi_s2[j] <= PROD_W'(win_s1[j]) * PROD_W'(hi_coef(j));
			end
		end
	end

	// Stage 3: sum each half of the taps
	always_ff @(posedge clk) begin
		acc_t lo_a, lo_b, hi_a, hi_b;
		if (adv_s3) begin
			lo_a = '0;
			lo_b = '0;
			hi_a = '0;
			hi_b = '0;
			for (int j = 0; j < HALF_TAPS; j++) begin
				lo_a = lo_a + ACC_W'(plo_s2[j]);
				hi_a = hi_a + ACC_W'(phi_s2[j]);
			end
			for (int j = HALF_TAPS; j < TAPS; j++) begin
				lo_b = lo_b + ACC_W'(plo_s2[j]);
				hi_b = hi_b + ACC_W'(phi_s2[j]);
			end
			slo_s3[0] <= lo_a;
			slo_s3[1] <= lo_b;
			shi_s3[0] <= hi_a;
			shi_s3[1] <= hi_b;
		end
	end

	// Output register: combine halves, round and clamp
	always_ff @(posedge clk) begin
		if (adv_out) begin
			approx <= round_sat(slo_s3[0] + slo_s3[1]);
			detail <= round_sat(shi_s3[0] + shi_s3[1]);
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_db7_dwt_analysis_filter_bank.sv -----
`default_nettype none
module tb_db7_dwt_analysis_filter_bank;
	import db7_pkg::*;

	// Run length guard: generous against the slowest correct run
	// (sender idling or receiver stalling 75 percent of the time).
	localparam int CYCLE_LIMIT  = 400000;
	// Cycles to let pass after the last expected result, so that the
	// pipeline can show any stray result.
	localparam int SETTLE_CYCLES = 12;
	localparam int RAND_PER_PHASE = 210;

	// db7 low-pass analysis taps in Q1.15; the high-pass set is derived
	// from these as the quadrature mirror.
	localparam int lowpass_taps [TAPS] = '{
		2551, 12994, 23892, 15394, -4716, -7341, 2337,
		2642, -1246, -543, 411, 14, -59, 12
	};

	typedef struct {
		sample_t smp;
		logic    fs;
	} sample_item_t;

	typedef struct {
		out_t approx;
		out_t detail;
	} coef_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [IN_W-1:0] sample = '0;
	logic frame_start = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [OUT_W-1:0] approx;
	logic signed [OUT_W-1:0] detail;

	// Samples waiting to be offered, and coefficient pairs waiting to come out
	sample_item_t pending_samples[$];
	coef_pair_t   expected_pairs[$];

	// Predictor state: sliding window, frame fill count, decimation phase
	sample_t window_mirror [TAPS];
	int      fill_mirror;
	bit      phase_mirror;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	db7_dwt_analysis_filter_bank dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.frame_start  (frame_start),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.approx       (approx),
		.detail       (detail)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bring a Q1.15 sum back to sample units: add half an LSB, floor-shift,
	// then clamp to the 18-bit output range.
	function automatic out_t to_sample_units(input longint acc);
		longint r;
		r = (acc + 64'sd16384) >>> 15;
		if (r > longint'(OUT_MAX)) begin
			r = longint'(OUT_MAX);
		end else if (r < longint'(OUT_MIN)) begin
			r = longint'(OUT_MIN);
		end
		return out_t'(r);
	endfunction

	// Shift one transferred sample into the window mirror and queue the
	// coefficient pair it produces, if any.
	task automatic advance_filter(input sample_t smp, input logic fs);
		longint acc_lo;
		longint acc_hi;
		longint hi_tap;
		coef_pair_t pair;
		// A frame start restarts the fill count and phase; old samples stay
		if (fs) begin
			fill_mirror = 0;
			phase_mirror = 1'b0;
		end
		for (int j = 0; j < TAPS - 1; j++) begin
			window_mirror[j] = window_mirror[j + 1];
		end
		window_mirror[TAPS - 1] = smp;
		if (fill_mirror < TAPS) begin
			fill_mirror++;
		end
		// Nothing comes out until the frame has filled the window
		if (fill_mirror < TAPS) begin
			return;
		end
		// Decimate by two: emit only on the even phase
		phase_mirror = ~phase_mirror;
		if (!phase_mirror) begin
			return;
		end
		acc_lo = 0;
		acc_hi = 0;
		for (int j = 0; j < TAPS; j++) begin
			hi_tap = lowpass_taps[TAPS - 1 - j];
			if (j % 2 == 1) begin
				hi_tap = -hi_tap;
			end
			acc_lo += longint'(window_mirror[j]) * lowpass_taps[j];
			acc_hi += longint'(window_mirror[j]) * hi_tap;
		end
		pair.approx = to_sample_units(acc_lo);
		pair.detail = to_sample_units(acc_hi);
		expected_pairs = {expected_pairs, pair};
	endtask

	// Favor the rails and tiny values over a plain uniform draw
	function automatic sample_t pick_sample();
		sample_t s;
		case ($urandom_range(9))
			0: s = 16'sh7FFF;
			1: s = 16'sh8000;
			2: s = sample_t'(int'($urandom_range(32)) - 16);
			default: s = sample_t'($urandom);
		endcase
		return s;
	endfunction

	task automatic push_sample(input sample_t smp, input logic fs);
		sample_item_t item;
		item.smp = smp;
		item.fs = fs;
		pending_samples = {pending_samples, item};
	endtask

	// Directed opening: windows driven to the extremes of both filters,
	// decimation across the frame, and a frame restart mid-stream.
	task automatic load_directed();
		int hi_tap;
		// Every sample at the rail matching the low-pass tap sign
		for (int j = 0; j < TAPS; j++) begin
			push_sample(lowpass_taps[j] >= 0 ? 16'sh7FFF : 16'sh8000, j == 0);
		end
		// One skipped by decimation, then one emitted
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7FFF, 1'b0);
		// Restart mid-stream, filling with rails matching the high-pass signs
		for (int j = 0; j < TAPS; j++) begin
			hi_tap = lowpass_taps[TAPS - 1 - j];
			if (j % 2 == 1) begin
				hi_tap = -hi_tap;
			end
			push_sample(hi_tap >= 0 ? 16'sh7FFF : 16'sh8000, j == 0);
		end
		push_sample(16'sh0000, 1'b0);
		push_sample(-16'sh0001, 1'b0);
	endtask

	// Random frames: mostly whole frames long enough to emit several pairs,
	// some cut short by an early restart, some continuing without a restart.
	task automatic load_random(input int count);
		int pushed;
		int len;
		int kind;
		pushed = 0;
		while (pushed < count) begin
			kind = $urandom_range(9);
			len = (kind == 0) ? $urandom_range(1, TAPS - 1) : $urandom_range(TAPS, 48);
			for (int i = 0; i < len; i++) begin
				push_sample(pick_sample(), (i == 0) && (kind != 1));
			end
			pushed += len;
		end
	endtask

	// Hold until every queued sample has transferred and every pair is out,
	// then give the pipeline time to show any stray result.
	task automatic drain();
		while (pending_samples.size() != 0 || sample_valid || expected_pairs.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sender: predict on each transfer, then offer the next sample or idle.
	// Valid and payload hold steady while the block is not ready.
	always @(posedge clk) begin : sample_driver
		sample_item_t item;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				advance_filter(sample, frame_start);
			end
			if (!sample_valid || sample_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item = pending_samples.pop_front();
					sample_valid <= 1'b1;
					sample <= item.smp;
					frame_start <= item.fs;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each transfer against the oldest expected pair,
	// then stall at random for the next cycle.
	always @(posedge clk) begin : result_monitor
		coef_pair_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_pairs.size() == 0) begin
					$display("%0t: unexpected result approx=%0d detail=%0d",
						$time, approx, detail);
					mismatch_count++;
				end else begin
					want = expected_pairs.pop_front();
					if (approx !== want.approx) begin
						$display("%0t: approx expected %0d, got %0d",
							$time, want.approx, approx);
						mismatch_count++;
					end
					if (detail !== want.detail) begin
						$display("%0t: detail expected %0d, got %0d",
							$time, want.detail, detail);
						mismatch_count++;
					end
				end
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int j = 0; j < TAPS; j++) begin
			window_mirror[j] = '0;
		end
		fill_mirror = 0;
		phase_mirror = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Four idling phases: none, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			if (ph == 0) begin
				load_directed();
			end
			load_random(RAND_PER_PHASE);
			drain();
		end

		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
